@@ rtl/est_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// est_pkg
// shared types, codes and reset tables for the editable state table
// ----------------------------------------------------------------------------
package est_pkg;

  // number of states asked for; the table holds at most eight, since a
  // state field is three bits wide
  localparam int NUM_STATES  = 8;
  localparam int TABLE_SLOTS = 8;
  localparam int USABLE      = (NUM_STATES < TABLE_SLOTS) ? NUM_STATES : TABLE_SLOTS;
  localparam logic [3:0] USABLE_W = 4'(USABLE);

  // action codes
  localparam logic [2:0] ACT_STEP   = 3'd0;
  localparam logic [2:0] ACT_CHANGE = 3'd1;
  localparam logic [2:0] ACT_READ   = 3'd2;
  localparam logic [2:0] ACT_REPORT = 3'd3;
  localparam logic [2:0] ACT_DELALL = 3'd4;
  localparam logic [2:0] ACT_DELONE = 3'd5;

  // status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_NOTHING  = 2'd2;

  // reset pointers, entry 0 in the lowest slot
  localparam logic [TABLE_SLOTS-1:0][2:0] RESET_ZERO =
    {3'd5, 3'd6, 3'd4, 3'd6, 3'd7, 3'd5, 3'd0, 3'd1};
  localparam logic [TABLE_SLOTS-1:0][2:0] RESET_ONE =
    {3'd1, 3'd2, 3'd3, 3'd3, 3'd0, 3'd7, 3'd6, 3'd4};

  typedef struct packed {
    logic [2:0] action;
    logic       bit_value;
    logic [2:0] target_state;
  } in_item_t;

  typedef struct packed {
    logic [2:0] current_now;
    logic [7:0] garbage_mask;
    logic [7:0] deleted_mask;
    logic       entry_live;
    logic [2:0] entry_next_zero;
    logic [2:0] entry_next_one;
    logic [1:0] status;
  } out_item_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the accepted item
    logic exec;   // run the captured item and register its result
  } dp_cmd_t;

  function automatic logic in_range(logic [2:0] s);
    return {1'b0, s} < USABLE_W;
  endfunction

  // reset pointer, falling back to the entry itself when out of range
  function automatic logic [2:0] reset_ptr(logic [2:0] idx, logic [2:0] v);
    return in_range(v) ? v : idx;
  endfunction

endpackage
`default_nettype wire

@@ rtl/est_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// est_ctrl
// sequencer: accepts one command, runs it, strobes the result
// ----------------------------------------------------------------------------
module est_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  output est_pkg::dp_cmd_t     cmd,
  output logic                 out_valid
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not make the block busy");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.exec))
    else $error("result strobe without an executed command");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire

@@ rtl/est_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// est_dp
// state table, present state, garbage detection and result register
// ----------------------------------------------------------------------------
module est_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire est_pkg::dp_cmd_t    cmd,
  input  wire est_pkg::in_item_t   in_data,
  output est_pkg::out_item_t       out_data
);

  localparam int SLOTS = est_pkg::TABLE_SLOTS;

  est_pkg::in_item_t          item_r;
  est_pkg::out_item_t         res_r, res_nxt;
  logic [2:0]                 present_r, present_nxt;
  logic [SLOTS-1:0]           live_r, live_nxt;
  logic [SLOTS-1:0][2:0]      nz_r, nz_nxt;
  logic [SLOTS-1:0][2:0]      no_r, no_nxt;

  logic [SLOTS-1:0]           referenced;
  logic [SLOTS-1:0]           garbage;
  logic [SLOTS-1:0]           cur_onehot;
  logic [SLOTS-1:0]           tgt_onehot;
  logic                       tgt_ok;

  // one-level reference check over all live entries, self loops ignored
  always_comb begin
    referenced = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (live_r[i]) begin
        if (nz_r[i] != 3'(i)) referenced[nz_r[i]] = 1'b1;
        if (no_r[i] != 3'(i)) referenced[no_r[i]] = 1'b1;
      end
    end
  end

  assign cur_onehot = SLOTS'(1) << present_r;
  assign tgt_onehot = SLOTS'(1) << item_r.target_state;
  assign garbage    = live_r & ~referenced & ~cur_onehot;
  assign tgt_ok     = est_pkg::in_range(item_r.target_state);

  always_comb begin
    present_nxt = present_r;
    live_nxt    = live_r;
    nz_nxt      = nz_r;
    no_nxt      = no_r;
    res_nxt     = '0;
    res_nxt.status = est_pkg::ST_DONE;
    case (item_r.action)
      est_pkg::ACT_STEP: begin
        present_nxt = item_r.bit_value ? no_r[present_r] : nz_r[present_r];
      end
      est_pkg::ACT_CHANGE: begin
        if (tgt_ok && live_r[item_r.target_state]) begin
          if (item_r.bit_value) no_nxt[present_r] = item_r.target_state;
          else                  nz_nxt[present_r] = item_r.target_state;
        end else begin
          res_nxt.status = est_pkg::ST_REJECTED;
        end
      end
      est_pkg::ACT_READ: begin
        if (tgt_ok) begin
          res_nxt.entry_live      = live_r[item_r.target_state];
          res_nxt.entry_next_zero = nz_r[item_r.target_state];
          res_nxt.entry_next_one  = no_r[item_r.target_state];
        end else begin
          res_nxt.status = est_pkg::ST_REJECTED;
        end
      end
      est_pkg::ACT_REPORT: begin
        res_nxt.garbage_mask = garbage;
        if (garbage == '0) res_nxt.status = est_pkg::ST_NOTHING;
      end
      est_pkg::ACT_DELALL: begin
        res_nxt.garbage_mask = garbage;
        res_nxt.deleted_mask = garbage;
        live_nxt             = live_r & ~garbage;
        if (garbage == '0) res_nxt.status = est_pkg::ST_NOTHING;
      end
      est_pkg::ACT_DELONE: begin
        res_nxt.garbage_mask = garbage;
        if (!tgt_ok) begin
          res_nxt.status = est_pkg::ST_REJECTED;
        end else if ((garbage & tgt_onehot) != '0) begin
          res_nxt.deleted_mask = tgt_onehot;
          live_nxt             = live_r & ~tgt_onehot;
        end else begin
          res_nxt.status = est_pkg::ST_NOTHING;
        end
      end
      default: begin
        res_nxt.status = est_pkg::ST_NOTHING;
      end
    endcase
    res_nxt.current_now = present_nxt;
  end

  // table state, restored to the reset tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        live_r[i] <= est_pkg::in_range(3'(i));
        nz_r[i]   <= est_pkg::reset_ptr(3'(i), est_pkg::RESET_ZERO[i]);
        no_r[i]   <= est_pkg::reset_ptr(3'(i), est_pkg::RESET_ONE[i]);
      end
    end else if (cmd.exec) begin
      present_r <= present_nxt;
      live_r    <= live_nxt;
      nz_r      <= nz_nxt;
      no_r      <= no_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.exec) res_r  <= res_nxt;
  end

  assign out_data = res_r;

endmodule
`default_nettype wire

@@ rtl/editable_state_table_with_garbage_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// editable_state_table_with_garbage_top
// table-driven state machine with editable pointers and garbage removal
// ----------------------------------------------------------------------------
// usage
//   a command transfer happens at a rising edge with start high and busy
//   low; in_data carries action, bit_value and target_state
//   each command gives exactly one result on out_data, marked by out_valid
//   for a single cycle; the receiver cannot stall, so it must take the
//   result in that cycle
// timing
//   the result strobe is high in the second cycle after the accepting edge
//   busy is high for the one cycle in which the command runs, so a new
//   command is taken every two cycles; the limit is the single execute
//   step of the sequencer in est_ctrl
// reset
//   rst_n low (synchronous) returns the present state to state 0, marks
//   every usable entry live and reloads the reset pointer tables; no result
//   is pending after reset
// ----------------------------------------------------------------------------
module editable_state_table_with_garbage_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire est_pkg::in_item_t   in_data,
  output logic                     out_valid,
  output est_pkg::out_item_t       out_data
);

  // command bus from sequencer to datapath
  est_pkg::dp_cmd_t cmd;

  // sequencer: idle, execute, strobe
  est_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  // table, garbage logic and result register
  est_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
